/* src/lr_pkg.sv */
// Shared constants and controller/datapath handshake types for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package lr_pkg;

   localparam int COORD_BITS_DEFAULT = 6;
   localparam int PIXEL_BITS         = 6;
   localparam int COLOR_BITS         = 24;

   typedef logic [PIXEL_BITS-1:0] pixel_coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;    // capture a new line item
      logic setup;   // work out deltas, directions and major axis
      logic step;    // present current pixel, advance one pixel
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;   // output register can take a pixel this cycle
      logic is_last;    // current pixel is the end pixel
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

endpackage
`default_nettype wire

/* src/lr_ctrl.sv */
// Line rasterizer controller: idle, setup and pixel run sequencing.
`timescale 1ns / 1ps
`default_nettype none
module lr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lr_pkg::status_type status,
   output lr_pkg::cmd_type         cmd
);

   lr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lr_pkg::ST_SETUP;
            end
         end
         lr_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = lr_pkg::ST_RUN;
         end
         lr_pkg::ST_RUN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.is_last) begin
                  state_in = lr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* src/lr_dpath.sv */
// Line rasterizer datapath: Bresenham stepping registers and pixel output register.
`timescale 1ns / 1ps
`default_nettype none
module lr_dpath #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lr_pkg::cmd_type         cmd,
   output lr_pkg::status_type           status,
   input  wire logic [COORD_BITS-1:0]   in_start_x,
   input  wire logic [COORD_BITS-1:0]   in_start_y,
   input  wire logic [COORD_BITS-1:0]   in_end_x,
   input  wire logic [COORD_BITS-1:0]   in_end_y,
   input  wire lr_pkg::color_type       in_color,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output lr_pkg::pixel_coord_type      rsp_pixel_x,
   output lr_pkg::pixel_coord_type      rsp_pixel_y,
   output lr_pkg::color_type            rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   localparam int ErrBits = COORD_BITS + 1;

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] end_x_ff, end_x_in;
   logic [COORD_BITS-1:0] end_y_ff, end_y_in;
   logic [COORD_BITS-1:0] delta_major_ff, delta_major_in;
   logic [COORD_BITS-1:0] delta_minor_ff, delta_minor_in;
   logic [COORD_BITS-1:0] steps_left_ff, steps_left_in;
   logic [ErrBits-1:0]    error_acc_ff, error_acc_in;
   logic                  x_is_major_ff, x_is_major_in;
   logic                  step_x_neg_ff, step_x_neg_in;
   logic                  step_y_neg_ff, step_y_neg_in;
   lr_pkg::color_type     held_color_ff, held_color_in;

   logic                    out_valid_ff, out_valid_in;
   lr_pkg::pixel_coord_type out_x_ff, out_x_in;
   lr_pkg::pixel_coord_type out_y_ff, out_y_in;
   lr_pkg::color_type       out_color_ff, out_color_in;
   logic                    out_last_ff, out_last_in;

   logic                  x_neg, y_neg;
   logic [COORD_BITS-1:0] dx, dy;
   logic [ErrBits-1:0]    err_sum;
   logic                  minor_step;
   logic [COORD_BITS-1:0] x_stepped, y_stepped;

   // setup arithmetic: start sits in cur_x/cur_y, end in end_x/end_y
   always_comb begin
      x_neg = end_x_ff < cur_x_ff;
      y_neg = end_y_ff < cur_y_ff;
      dx    = x_neg ? (cur_x_ff - end_x_ff) : (end_x_ff - cur_x_ff);
      dy    = y_neg ? (cur_y_ff - end_y_ff) : (end_y_ff - cur_y_ff);
   end

   // one Bresenham step
   always_comb begin
      err_sum    = error_acc_ff + {1'b0, delta_minor_ff};
      minor_step = err_sum >= {1'b0, delta_major_ff};
      x_stepped  = step_x_neg_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
      y_stepped  = step_y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
   end

   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign status.is_last  = steps_left_ff == '0;

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      delta_major_in = delta_major_ff;
      delta_minor_in = delta_minor_ff;
      steps_left_in  = steps_left_ff;
      error_acc_in   = error_acc_ff;
      x_is_major_in  = x_is_major_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      held_color_in  = held_color_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_color_in   = out_color_ff;
      out_last_in    = out_last_ff;

      if (cmd.load) begin
         cur_x_in      = in_start_x;
         cur_y_in      = in_start_y;
         end_x_in      = in_end_x;
         end_y_in      = in_end_y;
         held_color_in = in_color;
      end

      if (cmd.setup) begin
         step_x_neg_in  = x_neg;
         step_y_neg_in  = y_neg;
         x_is_major_in  = dx > dy;
         delta_major_in = (dx > dy) ? dx : dy;
         delta_minor_in = (dx > dy) ? dy : dx;
         steps_left_in  = (dx > dy) ? dx : dy;
         error_acc_in   = {1'b0, ((dx > dy) ? dx : dy)} >> 1;
      end

      if (cmd.step) begin
         out_valid_in = 1'b1;
         out_x_in     = lr_pkg::pixel_coord_type'(cur_x_ff);
         out_y_in     = lr_pkg::pixel_coord_type'(cur_y_ff);
         out_color_in = held_color_ff;
         out_last_in  = steps_left_ff == '0;
         error_acc_in = minor_step ? (err_sum - {1'b0, delta_major_ff}) : err_sum;
         if (x_is_major_ff) begin
            cur_x_in = x_stepped;
            if (minor_step) begin
               cur_y_in = y_stepped;
            end
         end else begin
            cur_y_in = y_stepped;
            if (minor_step) begin
               cur_x_in = x_stepped;
            end
         end
         steps_left_in = steps_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         delta_major_ff <= '0;
         delta_minor_ff <= '0;
         steps_left_ff  <= '0;
         error_acc_ff   <= '0;
         x_is_major_ff  <= 1'b0;
         step_x_neg_ff  <= 1'b0;
         step_y_neg_ff  <= 1'b0;
         held_color_ff  <= '0;
         out_x_ff       <= '0;
         out_y_ff       <= '0;
         out_color_ff   <= '0;
         out_last_ff    <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         end_x_ff       <= end_x_in;
         end_y_ff       <= end_y_in;
         delta_major_ff <= delta_major_in;
         delta_minor_ff <= delta_minor_in;
         steps_left_ff  <= steps_left_in;
         error_acc_ff   <= error_acc_in;
         x_is_major_ff  <= x_is_major_in;
         step_x_neg_ff  <= step_x_neg_in;
         step_y_neg_ff  <= step_y_neg_in;
         held_color_ff  <= held_color_in;
         out_x_ff       <= out_x_in;
         out_y_ff       <= out_y_in;
         out_color_ff   <= out_color_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_pixel  = out_last_ff;

endmodule
`default_nettype wire

/* src/line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: controller plus datapath.
//
// Each request item carries a start point, an end point and a 24-bit color; the block
// answers with one item per pixel on the line, start pixel first, end pixel last, the
// last one flagged by rsp_last_pixel. The major axis is x when |dx| > |dy| and y
// otherwise (ties go to y); each axis steps toward its own endpoint, so descending lines
// come out in start-to-end order. A zero-length line yields a single flagged pixel.
// For a line of n pixels (n = major delta + 1, at most 2**COORD_BITS), state idle takes
// the request, setup works out deltas and direction, then run moves one pixel per cycle
// from the single stepping unit into the output register while that register is free.
// A result stall pauses stepping. The next request is taken in the cycle after the last
// pixel enters the output register, even if that pixel is still waiting to be taken.
// COORD_BITS (4..6) sets the coordinate width used; with fewer than 6 bits the upper
// request bits are ignored and the pixel coordinates come out zero-extended.
`timescale 1ns / 1ps
`default_nettype none
module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_start_x,
   input  wire logic [5:0]  req_start_y,
   input  wire logic [5:0]  req_end_x,
   input  wire logic [5:0]  req_end_y,
   input  wire logic [23:0] req_line_color,
   // pixel result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_pixel_x,
   output logic [5:0]       rsp_pixel_y,
   output logic [23:0]      rsp_pixel_color,
   output logic             rsp_last_pixel
);

   lr_pkg::cmd_type    cmd;
   lr_pkg::status_type status;

   // sequencing: idle -> setup -> run (one pixel per free output slot)
   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // only the low COORD_BITS of each coordinate take part
   lr_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_start_x      (req_start_x[COORD_BITS-1:0]),
      .in_start_y      (req_start_y[COORD_BITS-1:0]),
      .in_end_x        (req_end_x[COORD_BITS-1:0]),
      .in_end_y        (req_end_y[COORD_BITS-1:0]),
      .in_color        (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
`default_nettype wire

/* src/lr_checker.sv */
// Port-level checks for the line rasterizer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_pixel_x,
   input wire logic [5:0]  rsp_pixel_y,
   input wire logic [23:0] rsp_pixel_color,
   input wire logic        rsp_last_pixel
);

   // nothing shows on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("stalled pixel changed");

   // a taken request makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a line is starting");

   // a non-final pixel on show means the line is still running
   a_busy_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |-> req_stall)
      else $error("request port open in mid line");

   // after a non-final pixel is taken the next one follows at once, same color
   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel && !rsp_stall
         |=> rsp_valid && rsp_pixel_color == $past(rsp_pixel_color))
      else $error("line broke off or changed color");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last_pixel  (rsp_last_pixel)
);
`default_nettype wire

/* tb/line_rasterizer_tb.sv */
// Self-checking testbench for line_rasterizer: directed and random lines, checked pixel by pixel.
`timescale 1ns / 1ps
module line_rasterizer_tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 80;      // longest line is 64 pixels plus setup
   localparam int SEGMENT_LINES = 40;
   localparam int SEGMENTS      = 9;       // 360 random lines
   localparam int FLOOD_SEGMENT = 4;
   localparam int FLOOD_LINES   = 8;
   localparam int HOLD_CYCLES   = 300;

   // One emitted pixel, as the result channel carries it.
   typedef struct packed {
      lr_pkg::pixel_coord_type x;
      lr_pkg::pixel_coord_type y;
      lr_pkg::color_type       color;
      logic                    last;
   } pixel_type;

   // One line request. Rows marked straight carry a hand-written expectation:
   // count pixels from the start, moving inc_x / inc_y per pixel.
   typedef struct packed {
      lr_pkg::pixel_coord_type sx;
      lr_pkg::pixel_coord_type sy;
      lr_pkg::pixel_coord_type ex;
      lr_pkg::pixel_coord_type ey;
      lr_pkg::color_type       color;
      logic                    straight;
      logic signed [1:0]       inc_x;
      logic signed [1:0]       inc_y;
      logic [6:0]              count;
   } line_row_type;

   localparam int N_DIRECTED = 20;
   localparam line_row_type DIRECTED_LINES [N_DIRECTED] = '{
      // zero-length lines: one flagged pixel
      '{6'd0,  6'd0,  6'd0,  6'd0,  24'h000000, 1'b1,  2'sd0,  2'sd0, 7'd1},
      '{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 1'b1,  2'sd0,  2'sd0, 7'd1},
      // full-length horizontal and vertical, both directions
      '{6'd0,  6'd0,  6'd63, 6'd0,  24'hFFFFFF, 1'b1,  2'sd1,  2'sd0, 7'd64},
      '{6'd63, 6'd63, 6'd0,  6'd63, 24'h000000, 1'b1, -2'sd1,  2'sd0, 7'd64},
      '{6'd0,  6'd0,  6'd0,  6'd63, 24'hAAAAAA, 1'b1,  2'sd0,  2'sd1, 7'd64},
      '{6'd63, 6'd63, 6'd63, 6'd0,  24'h555555, 1'b1,  2'sd0, -2'sd1, 7'd64},
      // full diagonals: a tie, so y is major and x steps on every pixel
      '{6'd0,  6'd0,  6'd63, 6'd63, 24'h123456, 1'b1,  2'sd1,  2'sd1, 7'd64},
      '{6'd63, 6'd63, 6'd0,  6'd0,  24'hFEDCBA, 1'b1, -2'sd1, -2'sd1, 7'd64},
      '{6'd63, 6'd0,  6'd0,  6'd63, 24'hFF0000, 1'b1, -2'sd1,  2'sd1, 7'd64},
      '{6'd0,  6'd63, 6'd63, 6'd0,  24'h00FF00, 1'b1,  2'sd1, -2'sd1, 7'd64},
      // two-pixel lines
      '{6'd10, 6'd10, 6'd11, 6'd11, 24'h0000FF, 1'b1,  2'sd1,  2'sd1, 7'd2},
      '{6'd20, 6'd20, 6'd21, 6'd20, 24'h808080, 1'b1,  2'sd1,  2'sd0, 7'd2},
      // shallow, steep and mixed-direction lines
      '{6'd0,  6'd0,  6'd63, 6'd1,  24'h7F7F7F, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd0,  6'd0,  6'd1,  6'd63, 24'h010101, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd63, 6'd63, 6'd0,  6'd62, 24'hC0FFEE, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd50, 6'd40, 6'd10, 6'd30, 24'h00AA55, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd5,  6'd60, 6'd9,  6'd2,  24'hA5A5A5, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd0,  6'd32, 6'd63, 6'd0,  24'h5A5A5A, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd7,  6'd3,  6'd2,  6'd7,  24'h0F0F0F, 1'b0,  2'sd0,  2'sd0, 7'd0},
      '{6'd31, 6'd31, 6'd32, 6'd33, 24'hF0F0F0, 1'b0,  2'sd0,  2'sd0, 7'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [5:0]  req_start_x    = '0;
   logic [5:0]  req_start_y    = '0;
   logic [5:0]  req_end_x      = '0;
   logic [5:0]  req_end_y      = '0;
   logic [23:0] req_line_color = '0;

   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [5:0]  rsp_pixel_x;
   logic [5:0]  rsp_pixel_y;
   logic [23:0] rsp_pixel_color;
   logic        rsp_last_pixel;

   pixel_type expected_pixels[$];
   int        failures    = 0;
   int        cycle_count = 0;

   // Pacing knobs, set by the stimulus process.
   bit source_idles     = 1'b1;
   bit sink_idles       = 1'b1;
   int long_hold_cycles = 0;

   always #2 clock = ~clock;

   line_rasterizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_line_color  (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   // Bresenham walk: error starts at half the major delta and gains the minor
   // delta per pixel; reaching the major delta steps the minor axis.
   task automatic trace_line(input line_row_type row);
      lr_pkg::pixel_coord_type cx, cy, dx, dy, d_major, d_minor;
      logic [6:0]              err;
      logic                    neg_x, neg_y, x_major, minor_step;
      int                      left;
      neg_x   = row.ex < row.sx;
      neg_y   = row.ey < row.sy;
      dx      = neg_x ? row.sx - row.ex : row.ex - row.sx;
      dy      = neg_y ? row.sy - row.ey : row.ey - row.sy;
      x_major = dx > dy;
      d_major = x_major ? dx : dy;
      d_minor = x_major ? dy : dx;
      err     = 7'(d_major >> 1);
      left    = d_major;
      cx      = row.sx;
      cy      = row.sy;
      expected_pixels.push_back('{cx, cy, row.color, left == 0});
      while (left != 0) begin
         err        = err + 7'(d_minor);
         minor_step = err >= 7'(d_major);
         if (minor_step) begin
            err = err - 7'(d_major);
         end
         if (x_major || minor_step) begin
            cx = neg_x ? cx - 6'd1 : cx + 6'd1;
         end
         if (!x_major || minor_step) begin
            cy = neg_y ? cy - 6'd1 : cy + 6'd1;
         end
         left--;
         expected_pixels.push_back('{cx, cy, row.color, left == 0});
      end
   endtask

   // Hand-written expectation for straight and diagonal rows.
   task automatic push_straight(input line_row_type row);
      lr_pkg::pixel_coord_type cx, cy;
      cx = row.sx;
      cy = row.sy;
      for (int i = 0; i < row.count; i++) begin
         expected_pixels.push_back('{cx, cy, row.color, i == row.count - 1});
         cx = cx + 6'(row.inc_x);
         cy = cy + 6'(row.inc_y);
      end
   endtask

   // Endpoint near a coordinate, kept inside the grid.
   function automatic lr_pkg::pixel_coord_type near_coord(input lr_pkg::pixel_coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(0, 14)) - 7;
      if (v < 0) begin
         v = 0;
      end else if (v > 63) begin
         v = 63;
      end
      return 6'(v);
   endfunction

   function automatic line_row_type random_line();
      line_row_type row;
      int unsigned  kind, d;
      row       = '0;
      row.color = 24'($urandom);
      row.sx    = 6'($urandom);
      row.sy    = 6'($urandom);
      kind      = $urandom_range(0, 19);
      if (kind < 9) begin
         row.ex = 6'($urandom);
         row.ey = 6'($urandom);
      end else if (kind < 15) begin
         row.ex = near_coord(row.sx);
         row.ey = near_coord(row.sy);
      end else if (kind == 15) begin
         row.ex = row.sx;
         row.ey = 6'($urandom);
      end else if (kind == 16) begin
         row.ex = 6'($urandom);
         row.ey = row.sy;
      end else if (kind < 19) begin
         // equal deltas: the y-major tie
         d      = $urandom_range(0, 31);
         row.ex = row.sx >= 6'd32 ? row.sx - 6'(d) : row.sx + 6'(d);
         row.ey = row.sy >= 6'd32 ? row.sy - 6'(d) : row.sy + 6'(d);
      end else begin
         row.ex = row.sx;
         row.ey = row.sy;
      end
      return row;
   endfunction

   // Full-length x-major line, used to fill the block under a long hold.
   function automatic line_row_type long_line();
      line_row_type row;
      row       = '0;
      row.color = 24'($urandom);
      row.sx    = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      row.ex    = 6'd63 - row.sx;
      row.sy    = 6'($urandom_range(1, 62));
      row.ey    = 6'($urandom_range(1, 62));
      return row;
   endfunction

   // Offer one line; the expectation is queued at the edge that takes it.
   task automatic offer_line(input line_row_type row);
      int unsigned gap;
      gap = source_idles ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start_x    <= row.sx;
      req_start_y    <= row.sy;
      req_end_x      <= row.ex;
      req_end_y      <= row.ey;
      req_line_color <= row.color;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (row.straight) begin
         push_straight(row);
      end else begin
         trace_line(row);
      end
   endtask

   // Result side pacing: a random pause before each pixel, and one long hold
   // on request.
   initial begin : pixel_sink
      int unsigned pause;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end
         pause = sink_idles ? $urandom_range(0, 8) : 0;
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            failures++;
            $display("%0t: pixel mismatch expected none got x=%0d y=%0d color=%06h last=%0b",
                     $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y ||
                rsp_pixel_color !== want.color || rsp_last_pixel !== want.last) begin
               failures++;
               $display("%0t: pixel mismatch expected x=%0d y=%0d color=%06h last=%0b",
                        $time, want.x, want.y, want.color, want.last);
               $display("%0t:                got      x=%0d y=%0d color=%06h last=%0b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                        rsp_last_pixel);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_LINES[i]) begin
         offer_line(DIRECTED_LINES[i]);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // some segments run with no idling on one or both sides
         source_idles = $urandom_range(0, 3) != 0;
         sink_idles   = $urandom_range(0, 3) != 0;
         if (seg == FLOOD_SEGMENT) begin
            // back-to-back long lines against a stalled result side
            long_hold_cycles = HOLD_CYCLES;
            source_idles     = 1'b0;
            repeat (FLOOD_LINES) offer_line(long_line());
            source_idles     = 1'b1;
         end
         repeat (SEGMENT_LINES) offer_line(random_line());
      end
      req_valid <= 1'b0;

      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
src/lr_pkg.sv
src/lr_ctrl.sv
src/lr_dpath.sv
src/line_rasterizer.sv
src/lr_checker.sv
tb/line_rasterizer_tb.sv
